### design/assert_macros.svh
// assertion macros for the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/piqu_pkg.sv
// shared types, register indexes and constants of the packed iq sample unpacker
// no dependencies
`default_nettype none

package piqu_pkg;

	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_BUFFER_DEPTH = 65536;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CODE_VALUE_0  = 3'd0,
		REG_CODE_VALUE_1  = 3'd1,
		REG_CODE_VALUE_2  = 3'd2,
		REG_CODE_VALUE_3  = 3'd3,
		REG_CHANNEL_COUNT = 3'd4,
		REG_BITS_PER_CODE = 3'd5,
		REG_COMPLEX_MODE  = 3'd6
	} reg_idx_t;

	localparam logic [7:0] RST_CODE_VALUE_0  = 8'h01;
	localparam logic [7:0] RST_CODE_VALUE_1  = 8'h03;
	localparam logic [7:0] RST_CODE_VALUE_2  = 8'hFD;
	localparam logic [7:0] RST_CODE_VALUE_3  = 8'hFF;
	localparam logic [3:0] RST_CHANNEL_COUNT = 4'd2;
	localparam logic [1:0] RST_BITS_PER_CODE = 2'd2;
	localparam logic       RST_COMPLEX_MODE  = 1'b1;

	typedef struct packed {
		logic [3:0][7:0] code_value;
		logic [3:0]      channel_count;
		logic [1:0]      bits_per_code;
		logic            complex_mode;
	} cfg_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       buffer_start;
	} item_t;

	// head of the byte queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

`default_nettype wire

### design/piqu_front.sv
// front end: accepts input words and holds them in a short byte queue
// depends on piqu_pkg
`default_nettype none

module piqu_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_valid,
	output logic               s_ready,
	input  wire piqu_pkg::item_t s_item,
	output piqu_pkg::head_t    head,
	input  wire                pop
);

	piqu_pkg::item_t                     mem_q [piqu_pkg::QUEUE_DEPTH];
	logic [piqu_pkg::QPTR_W-1:0]         wptr_q;
	logic [piqu_pkg::QPTR_W-1:0]         rptr_q;
	logic [piqu_pkg::QCNT_W-1:0]         cnt_q;
	logic                                push;
	logic                                do_pop;

	assign s_ready = (cnt_q != piqu_pkg::QCNT_W'(piqu_pkg::QUEUE_DEPTH));
	assign push    = s_valid && s_ready;
	assign do_pop  = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= s_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == piqu_pkg::QPTR_W'(piqu_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == piqu_pkg::QPTR_W'(piqu_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/piqu_back.sv
// back end: walks the codes of the head byte, one per cycle while the output is not stalled,
// maps them and keeps the component, channel and position counters; depends on piqu_pkg
`default_nettype none

module piqu_back #(
	parameter int MAX_CHANNELS = piqu_pkg::DEF_MAX_CHANNELS,
	parameter int BUFFER_DEPTH = piqu_pkg::DEF_BUFFER_DEPTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire piqu_pkg::cfg_t  cfg,
	input  wire piqu_pkg::head_t head,
	output logic               pop,
	output logic               m_valid,
	input  wire                m_ready,
	output logic [7:0]         sample_value,
	output logic [2:0]         channel_index,
	output logic [15:0]        buffer_position,
	output logic               is_quadrature,
	output logic               last_of_byte
);

	localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNW = $clog2(MAX_CHANNELS + 1);
	localparam int PW  = $clog2(BUFFER_DEPTH);
	localparam logic [PW:0] DEPTH_V = (PW + 1)'(BUFFER_DEPTH);

	logic            comp_q;
	logic [CW-1:0]   ch_q;
	logic [PW-1:0]   pos_q;
	logic [2:0]      idx_q;

	logic            out_valid_q;
	logic [7:0]      sample_q;
	logic [CW-1:0]   chan_q;
	logic [PW-1:0]   posout_q;
	logic            quad_q;
	logic            last_q;

	logic            adv;
	logic            two_bit;
	logic            last_code;
	logic [2:0]      shamt;
	logic [7:0]      shifted;
	logic [1:0]      code;
	logic [CNW-1:0]  eff_count;
	logic [CNW-1:0]  ch_inc;
	logic            ch_wrap;
	logic [CW-1:0]   ch_next;
	logic [PW-1:0]   base;
	logic            quad;
	logic [PW:0]     sum_out;
	logic [PW-1:0]   pos_out;
	logic [PW:0]     sum_adv;
	logic [PW-1:0]   pos_adv;

	assign adv = head.valid && (!out_valid_q || m_ready);

	// bits_per_code of 2 or 3 means two-bit codes, 0 or 1 means one-bit codes
	assign two_bit   = cfg.bits_per_code[1];
	assign last_code = two_bit ? (idx_q[1:0] == 2'd3) : (idx_q == 3'd7);
	assign shamt     = two_bit ? {idx_q[1:0], 1'b0} : idx_q;
	assign shifted   = head.item.packed_byte >> shamt;
	assign code      = two_bit ? shifted[1:0] : {1'b0, shifted[0]};
	assign pop       = adv && last_code;

	always_comb begin
		if (cfg.channel_count == '0) begin
			eff_count = CNW'(1);
		end else if (8'(cfg.channel_count) > 8'(MAX_CHANNELS)) begin
			eff_count = CNW'(MAX_CHANNELS);
		end else begin
			eff_count = CNW'(cfg.channel_count);
		end
	end

	assign ch_inc  = CNW'(ch_q) + 1'b1;
	assign ch_wrap = (ch_inc >= eff_count);
	assign ch_next = ch_wrap ? '0 : CW'(ch_inc);

	// start-of-buffer restarts the position before the first code of the byte
	assign base = (head.item.buffer_start && (idx_q == 3'd0)) ? '0 : pos_q;
	assign quad = cfg.complex_mode && comp_q;

	assign sum_out = {1'b0, base} + (PW + 1)'(quad);
	assign pos_out = (sum_out >= DEPTH_V) ? PW'(sum_out - DEPTH_V) : PW'(sum_out);
	assign sum_adv = {1'b0, base} + (cfg.complex_mode ? (PW + 1)'(2) : (PW + 1)'(1));
	assign pos_adv = (sum_adv >= DEPTH_V) ? PW'(sum_adv - DEPTH_V) : PW'(sum_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q      <= 1'b0;
			ch_q        <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_code ? 3'd0 : idx_q + 3'd1;
				if (cfg.complex_mode) begin
					comp_q <= ~comp_q;
					if (comp_q) begin
						ch_q  <= ch_next;
						pos_q <= ch_wrap ? pos_adv : base;
					end else begin
						pos_q <= base;
					end
				end else begin
					ch_q  <= ch_next;
					pos_q <= ch_wrap ? pos_adv : base;
				end
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_q <= cfg.code_value[code];
			chan_q   <= ch_q;
			posout_q <= pos_out;
			quad_q   <= quad;
			last_q   <= last_code;
		end
	end

	assign m_valid         = out_valid_q;
	assign sample_value    = sample_q;
	assign channel_index   = 3'(chan_q);
	assign buffer_position = 16'(posout_q);
	assign is_quadrature   = quad_q;
	assign last_of_byte    = last_q;

endmodule

`default_nettype wire

### design/packed_iq_sample_unpacker.sv
// top level of the packed iq sample unpacker: configuration registers,
// front byte queue and back code sequencer; depends on piqu_pkg, piqu_front, piqu_back
//
// channel   | dir | handshake              | payload
// s_axis    | in  | tvalid/tready          | tdata: packed byte, tuser: buffer start
// m_axis    | out | tvalid/tready          | tdata: value, channel, position; tuser, tlast
// cfg       | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
// one output word per cycle while the output is not stalled; a byte holds 4 two-bit
// codes or 8 one-bit codes, as the back end emits one code per cycle
// first word of a byte passes through the byte queue, then the output register
// the two-entry byte queue holds the byte in work plus one waiting byte; input
// stalls once both are taken, until the back end pops the byte in work
// arst_n clears the counters, queue and output valid; registers return to defaults
`default_nettype none

module packed_iq_sample_unpacker #(
	parameter int MAX_CHANNELS = piqu_pkg::DEF_MAX_CHANNELS,
	parameter int BUFFER_DEPTH = piqu_pkg::DEF_BUFFER_DEPTH
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [7:0]                          s_axis_tdata,  // [7:0] packed_byte
	input  wire                                 s_axis_tuser,  // [0] buffer_start
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [7:0] sample_value, [10:8] channel_index, [26:11] buffer_position, [31:27] zero
	output logic [piqu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tuser,  // [0] is_quadrature
	output logic                                m_axis_tlast,  // last_of_byte
	input  wire                                 cfg_we,
	input  wire  [piqu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [piqu_pkg::CFG_DATA_W-1:0]     cfg_data
);

	piqu_pkg::cfg_t   cfg_q;
	piqu_pkg::item_t  s_item;
	piqu_pkg::head_t  head;
	logic             pop;
	logic [7:0]       sample_value;
	logic [2:0]       channel_index;
	logic [15:0]      buffer_position;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_value[0] <= piqu_pkg::RST_CODE_VALUE_0;
			cfg_q.code_value[1] <= piqu_pkg::RST_CODE_VALUE_1;
			cfg_q.code_value[2] <= piqu_pkg::RST_CODE_VALUE_2;
			cfg_q.code_value[3] <= piqu_pkg::RST_CODE_VALUE_3;
			cfg_q.channel_count <= piqu_pkg::RST_CHANNEL_COUNT;
			cfg_q.bits_per_code <= piqu_pkg::RST_BITS_PER_CODE;
			cfg_q.complex_mode  <= piqu_pkg::RST_COMPLEX_MODE;
		end else if (cfg_we) begin
			case (cfg_index)
				piqu_pkg::REG_CODE_VALUE_0:  cfg_q.code_value[0] <= cfg_data;
				piqu_pkg::REG_CODE_VALUE_1:  cfg_q.code_value[1] <= cfg_data;
				piqu_pkg::REG_CODE_VALUE_2:  cfg_q.code_value[2] <= cfg_data;
				piqu_pkg::REG_CODE_VALUE_3:  cfg_q.code_value[3] <= cfg_data;
				piqu_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[3:0];
				piqu_pkg::REG_BITS_PER_CODE: cfg_q.bits_per_code <= cfg_data[1:0];
				piqu_pkg::REG_COMPLEX_MODE:  cfg_q.complex_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_item.packed_byte  = s_axis_tdata;
	assign s_item.buffer_start = s_axis_tuser;

	piqu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_item  (s_item),
		.head    (head),
		.pop     (pop)
	);

	piqu_back #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.head            (head),
		.pop             (pop),
		.m_valid         (m_axis_tvalid),
		.m_ready         (m_axis_tready),
		.sample_value    (sample_value),
		.channel_index   (channel_index),
		.buffer_position (buffer_position),
		.is_quadrature   (m_axis_tuser),
		.last_of_byte    (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, buffer_position, channel_index, sample_value};

endmodule

`default_nettype wire

### design/piqu_checker.sv
// port-level checks of the packed iq sample unpacker, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module piqu_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [31:0] m_axis_tdata
);

	// a stalled output word keeps its data
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

	// padding above the position field stays zero
	`ASSERT_IMPL(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[31:27] == 5'd0, "tdata padding not zero")

	// a full byte queue means the back end is presenting a word
	`ASSERT_IMPL(a_full_busy, clk, arst_n, !s_axis_tready, m_axis_tvalid, "input stalled with no output word")

	// input side only stalls while output is stalled or still draining
	`ASSERT_NEXT(a_stall_cause, clk, arst_n, !s_axis_tready && m_axis_tready, m_axis_tvalid, "output gap while queue full")

endmodule

bind packed_iq_sample_unpacker piqu_checker u_piqu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
